>>> hdl/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared constants for the serial bank mapper: access modes, error codes,
// register selects, register reset values and bank limits.
// ----------------------------------------------------------------------------
package sbm_pkg;

    localparam int unsigned PRG_BANKS_MAX = 16;

    localparam logic [1:0] MODE_CPU_READ  = 2'd0;
    localparam logic [1:0] MODE_PPU_READ  = 2'd1;
    localparam logic [1:0] MODE_CPU_WRITE = 2'd2;
    localparam logic [1:0] MODE_PPU_WRITE = 2'd3;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_PRG_RAM = 2'd1;
    localparam logic [1:0] ERR_CPU     = 2'd2;
    localparam logic [1:0] ERR_PPU     = 2'd3;

    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_CHR_LOW  = 2'd1;
    localparam logic [1:0] REG_CHR_HIGH = 2'd2;
    localparam logic [1:0] REG_PRG      = 2'd3;

    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    localparam logic [4:0] SHIFT_EMPTY     = 5'h10;
    localparam logic [4:0] CTRL_RESET      = 5'h0C;
    localparam logic [4:0] CHR_LOW_RESET   = 5'd0;
    localparam logic [4:0] CHR_HIGH_RESET  = 5'd1;
    localparam logic [3:0] PRG_LOW_RESET   = 4'd0;
    localparam logic [3:0] PRG_HIGH_RESET  = 4'd1;
    localparam logic [4:0] PRG_COUNT_RESET = 5'd2;

    localparam logic [4:0] PRG_BANKS_MAX_W = 5'(PRG_BANKS_MAX);

endpackage

>>> hdl/serial_bank_mapper.sv
// ----------------------------------------------------------------------------
// serial_bank_mapper
// Cartridge bank switcher with serial register loading: translates CPU and
// PPU bus accesses into PRG or CHR ROM byte offsets.
// ----------------------------------------------------------------------------
// One access is taken per cycle unless stalled; its result appears in the
// output register on the next cycle. Bank state is updated at the accepting
// edge, so a write affects the very next access. o_in_ready is low only while
// the output register holds a result the sink is not taking in that cycle.
module serial_bank_mapper
    import sbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_target_rom,
    output logic [17:0] o_rom_offset,
    output logic [1:0]  o_error_code
);

    logic [4:0]  r_prg_count;
    logic [4:0]  r_shift, n_shift;
    logic [4:0]  r_ctrl, n_ctrl;
    logic [4:0]  r_chr_low, n_chr_low;
    logic [4:0]  r_chr_high, n_chr_high;
    logic [3:0]  r_prg_low, n_prg_low;
    logic [3:0]  r_prg_high, n_prg_high;

    logic        r_out_valid;
    logic        r_target, n_target;
    logic [17:0] r_offset, n_offset;
    logic [1:0]  r_err, n_err;

    logic        accept;
    logic [4:0]  value;
    logic [3:0]  last_bank;
    logic [12:0] chr_split;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign value      = {i_write_data[0], r_shift[4:1]};
    assign chr_split  = r_ctrl[4] ? 13'h1000 : 13'h0000;

    always_comb begin
        if (r_prg_count == 5'd0) begin
            last_bank = 4'd0;
        end else if (r_prg_count > PRG_BANKS_MAX_W) begin
            last_bank = 4'(PRG_BANKS_MAX_W - 5'd1);
        end else begin
            last_bank = 4'(r_prg_count - 5'd1);
        end
    end

    // result of the access
    always_comb begin
        n_target = 1'b0;
        n_offset = '0;
        n_err    = ERR_OK;
        case (i_mode)
            MODE_CPU_READ: begin
                if (i_address[15:14] == 2'b11) begin
                    n_offset = {r_prg_high, i_address[13:0]};
                end else if (i_address[15]) begin
                    n_offset = {r_prg_low, i_address[13:0]};
                end else if (i_address[14:13] == 2'b11) begin
                    n_err = ERR_PRG_RAM;
                end else begin
                    n_err = ERR_CPU;
                end
            end
            MODE_PPU_READ: begin
                n_target = 1'b1;
                if (i_address[15:13] != 3'd0) begin
                    n_err = ERR_PPU;
                end else if (!r_ctrl[4] || (i_address[12:0] < chr_split)) begin
                    n_offset = {1'b0, r_chr_low, 12'h000} + {5'd0, i_address[12:0]};
                end else begin
                    n_offset = {1'b0, r_chr_high, i_address[11:0]};
                end
            end
            default: begin
            end
        endcase
    end

    // serial register and bank updates
    always_comb begin
        n_shift    = r_shift;
        n_ctrl     = r_ctrl;
        n_chr_low  = r_chr_low;
        n_chr_high = r_chr_high;
        n_prg_low  = r_prg_low;
        n_prg_high = r_prg_high;
        if ((i_mode == MODE_CPU_WRITE) && i_address[15]) begin
            if (i_write_data[7]) begin
                n_shift = SHIFT_EMPTY;
                n_ctrl  = r_ctrl | CTRL_RESET;
            end else if (!r_shift[0]) begin
                n_shift = value;
            end else begin
                n_shift = SHIFT_EMPTY;
                case (i_address[14:13])
                    REG_CONTROL: n_ctrl = value;
                    REG_CHR_LOW: n_chr_low = r_ctrl[4] ? value : {value[4:1], 1'b0};
                    REG_CHR_HIGH: begin
                        if (r_ctrl[4]) begin
                            n_chr_high = value;
                        end
                    end
                    REG_PRG: begin
                        case (r_ctrl[3:2])
                            PRG_MODE_FIX_FIRST: begin
                                n_prg_low  = 4'd0;
                                n_prg_high = value[3:0];
                            end
                            PRG_MODE_FIX_LAST: begin
                                n_prg_low  = value[3:0];
                                n_prg_high = last_bank;
                            end
                            default: begin
                                n_prg_low  = {value[3:1], 1'b0};
                                n_prg_high = {value[3:1], 1'b1};
                            end
                        endcase
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count <= PRG_COUNT_RESET;
            r_shift     <= SHIFT_EMPTY;
            r_ctrl      <= CTRL_RESET;
            r_chr_low   <= CHR_LOW_RESET;
            r_chr_high  <= CHR_HIGH_RESET;
            r_prg_low   <= PRG_LOW_RESET;
            r_prg_high  <= PRG_HIGH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prg_count <= i_cfg_data;
            end
            if (accept) begin
                r_shift    <= n_shift;
                r_ctrl     <= n_ctrl;
                r_chr_low  <= n_chr_low;
                r_chr_high <= n_chr_high;
                r_prg_low  <= n_prg_low;
                r_prg_high <= n_prg_high;
            end
            if (o_in_ready) begin
                r_out_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target <= n_target;
            r_offset <= n_offset;
            r_err    <= n_err;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_target_rom = r_target;
    assign o_rom_offset = r_offset;
    assign o_error_code = r_err;

endmodule

>>> hdl/sbm_checker.sv
// ----------------------------------------------------------------------------
// sbm_checker
// Port-level checks for the serial bank mapper, bound to the serial_bank_mapper module.
// ----------------------------------------------------------------------------
module sbm_checker
    import sbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic        o_target_rom,
    input  logic [17:0] o_rom_offset,
    input  logic [1:0]  o_error_code
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_target_rom)
            && $stable(o_rom_offset) && $stable(o_error_code))
        else $error("result beat changed while stalled");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted beat gave no result on the next cycle");

    a_err_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != ERR_OK) |-> o_rom_offset == 18'd0)
        else $error("error result with non-zero offset");

    a_err_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code != ERR_OK) |->
            (o_target_rom == (o_error_code == ERR_PPU)))
        else $error("error code does not match target ROM");

endmodule

bind serial_bank_mapper sbm_checker u_sbm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_target_rom (o_target_rom),
    .o_rom_offset (o_rom_offset),
    .o_error_code (o_error_code)
);
